@@ rtl/polynomial_coefficient_engine_defines.svh @@
// Assertion macros shared by the polynomial coefficient engine RTL.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef POLYNOMIAL_COEFFICIENT_ENGINE_DEFINES_SVH
`define POLYNOMIAL_COEFFICIENT_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCE_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCE_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);

`endif

@@ rtl/pce_pkg.sv @@
// Package for the polynomial coefficient engine: word types, command codes,
// and the saturating fixed-point helpers. No dependencies.
package pce_pkg;

  localparam int MAX_TERMS_DEF = 16;
  localparam int ROW_W = 33;

  localparam logic [3:0] CMD_WRITE  = 4'd0;
  localparam logic [3:0] CMD_READ   = 4'd1;
  localparam logic [3:0] CMD_EVAL   = 4'd2;
  localparam logic [3:0] CMD_ADDC   = 4'd3;
  localparam logic [3:0] CMD_SCALE  = 4'd4;
  localparam logic [3:0] CMD_SCALEX = 4'd5;
  localparam logic [3:0] CMD_SHIFT  = 4'd6;
  localparam logic [3:0] CMD_SHINC  = 4'd7;
  localparam logic [3:0] CMD_ADDSUB = 4'd8;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic [ROW_W-1:0] ROW_CAP = 33'h1_0000_0000;

  typedef struct packed {
    logic [3:0]         cmd;
    logic [3:0]         index;
    logic               subtract;
    logic signed [31:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [4:0]         term_count;
    logic               overflow;
  } rsp_word_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } sat_t;

  // Clamp a wide signed value to 32 bits.
  function automatic sat_t sat_wide(input logic signed [66:0] v);
    sat_t r;
    r.sat = 1'b0;
    r.val = v[31:0];
    if (v > 67'sh7fff_ffff) begin
      r.sat = 1'b1;
      r.val = Q_MAX;
    end else if (v < -67'sh8000_0000) begin
      r.sat = 1'b1;
      r.val = Q_MIN;
    end
    return r;
  endfunction

  // Exact sum of a coefficient and a 33-bit operand, then clamped.
  function automatic sat_t sat_add(input logic signed [31:0] a, input logic signed [32:0] b);
    logic signed [66:0] s;
    s = 67'(a) + 67'(b);
    return sat_wide(s);
  endfunction

  // Binomial row update; values at or above 2^32 are held at the cap.
  function automatic logic [ROW_W-1:0] row_add(input logic [ROW_W-1:0] a,
                                                input logic [ROW_W-1:0] b);
    logic [ROW_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, ROW_CAP}) return ROW_CAP;
    return s[ROW_W-1:0];
  endfunction

endpackage

@@ rtl/pce_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module pce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when enabled, otherwise read into the output register.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/pce_mul.sv @@
// Shared multiplier: registered 33x33 product, then Q16.16 rounding or a
// plain integer clamp. Depends on pce_pkg.
module pce_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  input  logic               q_mode,
  output pce_pkg::sat_t      res
);

  logic signed [65:0] prod;
  logic               mode;
  logic signed [66:0] rnd;

  // Product register; the result follows in the cycle after the operands.
  always_ff @(posedge clk) begin
    prod <= a * b;
    mode <= q_mode;
  end

  // In Q16.16 mode, round to nearest with ties upward; in either mode, clamp.
  always_comb begin
    rnd = (67'(prod) + 67'sd32768) >>> 16;
    if (mode) begin
      res = pce_pkg::sat_wide(rnd);
    end else begin
      res = pce_pkg::sat_wide(67'(prod));
    end
  end

endmodule

@@ rtl/polynomial_coefficient_engine.sv @@
// Polynomial coefficient engine top level: command sequencer over the
// coefficient RAM and the power/binomial RAM. Depends on pce_pkg, pce_ram, pce_mul.
//
// One command word yields one response word. Commands run one at a time on a
// single shared multiplier and two single-port RAMs, so the cost per word is
// set by RAM and multiplier turns, and for evaluate, scale and scale x it grows
// with the term count n. The Taylor shifts build the power table, then for each
// power i from 1 to n-1 update the binomial row and, when coefficient i is
// nonzero, spread it into every lower term (the incremental form also writes
// coefficient i back), so their cost grows with the square of n. The coefficient
// table needs no clearing pass: per-entry valid bits make unwritten entries read
// as zero right after reset. A new command word is taken whenever the sequencer
// is idle, even while the previous response word still waits to be taken.
module polynomial_coefficient_engine #(
  parameter int MAX_TERMS = pce_pkg::MAX_TERMS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  pce_pkg::cmd_word_t  cmd_word,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output pce_pkg::rsp_word_t  rsp_word
);

`include "polynomial_coefficient_engine_defines.svh"

  localparam int AW = $clog2(MAX_TERMS);
  localparam int CW = (AW + 1 > 5) ? AW + 1 : 5;
  localparam int XW = pce_pkg::ROW_W + 32;

  typedef enum logic [4:0] {
    S_IDLE, S_WR, S_RD, S_RD_W, S_EV_CHK, S_EV_ACC, S_RMW_RD, S_RMW_WR,
    S_SC_RD, S_SC_MUL, S_SC_WR, S_SX_RD, S_SX_MUL, S_SX_WR, S_SX_M2,
    S_SH_P0, S_SH_PCHK, S_SH_PWR, S_SH_ICHK, S_SH_CUR, S_SH_RROW, S_SH_ROW,
    S_SH_RPOW, S_SH_MB, S_SH_SB, S_SH_MQ, S_SH_ADD, S_SH_ROLL, S_SH_WRI, S_DONE
  } state_t;

  state_t state;

  logic [3:0]         cmd_q;
  logic [3:0]         idx_q;
  logic               sub_q;
  logic signed [31:0] val_q;
  logic [4:0]         count;
  logic               sat;
  logic signed [31:0] res;
  logic [CW-1:0]      i, j, k;
  logic signed [31:0] cur, roll, m, cj, pw, sb;
  logic [pce_pkg::ROW_W-1:0] binom, prev_row;
  logic [MAX_TERMS-1:0] vld;
  logic               rd_vld;

  logic [AW-1:0]      c_addr, a_addr;
  logic               c_we, a_we;
  logic signed [31:0] c_wdata, c_rdata;
  logic [XW-1:0]      a_wdata, a_rdata;
  logic signed [32:0] mul_a, mul_b;
  logic               mul_q;
  pce_pkg::sat_t      mul_o;
  logic signed [31:0] add_a;
  logic signed [32:0] add_b;
  pce_pkg::sat_t      add_o;

  logic [CW-1:0]      cnt_w;
  logic               idx_ok, idx_q_ok, inc;
  logic signed [31:0] crd_m, f, aux_pow;
  logic [pce_pkg::ROW_W-1:0] aux_row, row_new;
  logic [AW-1:0]      rmw_addr;
  logic signed [32:0] rmw_op;

  pce_ram #(.WIDTH(32), .DEPTH(MAX_TERMS)) u_coef (
    .clk(clk), .addr(c_addr), .we(c_we), .wdata(c_wdata), .rdata(c_rdata)
  );

  pce_ram #(.WIDTH(XW), .DEPTH(MAX_TERMS)) u_aux (
    .clk(clk), .addr(a_addr), .we(a_we), .wdata(a_wdata), .rdata(a_rdata)
  );

  pce_mul u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .q_mode(mul_q), .res(mul_o)
  );

  // Shared decode of incoming and held command fields and memory read data.
  always_comb begin
    cnt_w    = CW'(count);
    idx_ok   = CW'(cmd_word.index) < CW'(MAX_TERMS);
    idx_q_ok = CW'(idx_q) < CW'(MAX_TERMS);
    inc      = (cmd_q == pce_pkg::CMD_SHINC);
    crd_m    = rd_vld ? c_rdata : '0;
    aux_row  = a_rdata[XW-1:32];
    aux_pow  = a_rdata[31:0];
    row_new  = pce_pkg::row_add(aux_row, prev_row);
    f        = inc ? roll : cur;
    rmw_addr = (cmd_q == pce_pkg::CMD_ADDSUB) ? AW'(idx_q) : '0;
    rmw_op   = (cmd_q == pce_pkg::CMD_ADDSUB && sub_q) ? -33'(val_q) : 33'(val_q);
    add_o    = pce_pkg::sat_add(add_a, add_b);
  end

  // Memory, multiplier and adder controls for each sequencer state.
  always_comb begin
    c_addr  = '0;
    c_we    = 1'b0;
    c_wdata = '0;
    a_addr  = '0;
    a_we    = 1'b0;
    a_wdata = '0;
    mul_a   = '0;
    mul_b   = '0;
    mul_q   = 1'b1;
    add_a   = '0;
    add_b   = '0;
    unique case (state)
      S_WR: begin
        c_addr  = AW'(idx_q);
        c_we    = 1'b1;
        c_wdata = val_q;
      end
      S_RD: c_addr = AW'(idx_q);
      S_EV_CHK: begin
        c_addr = AW'(i - CW'(1));
        mul_a  = 33'(res);
        mul_b  = 33'(val_q);
      end
      S_EV_ACC: begin
        add_a = mul_o.val;
        add_b = 33'(crd_m);
      end
      S_RMW_RD: c_addr = rmw_addr;
      S_RMW_WR: begin
        add_a   = crd_m;
        add_b   = rmw_op;
        c_addr  = rmw_addr;
        c_we    = 1'b1;
        c_wdata = add_o.val;
      end
      S_SC_RD, S_SX_RD: c_addr = i[AW-1:0];
      S_SC_MUL: begin
        mul_a = 33'(crd_m);
        mul_b = 33'(val_q);
      end
      S_SX_MUL: begin
        mul_a = 33'(crd_m);
        mul_b = 33'(m);
      end
      S_SC_WR: begin
        c_addr  = i[AW-1:0];
        c_we    = 1'b1;
        c_wdata = mul_o.val;
      end
      S_SX_WR: begin
        c_addr  = i[AW-1:0];
        c_we    = 1'b1;
        c_wdata = mul_o.val;
        mul_a   = 33'(m);
        mul_b   = 33'(val_q);
      end
      S_SH_P0: begin
        a_we    = 1'b1;
        a_wdata = {33'd1, pce_pkg::Q_ONE};
      end
      S_SH_PCHK: begin
        mul_a = 33'(m);
        mul_b = 33'(val_q);
      end
      S_SH_PWR: begin
        a_addr  = k[AW-1:0];
        a_we    = 1'b1;
        a_wdata = {33'd0, mul_o.val};
      end
      S_SH_ICHK: c_addr = i[AW-1:0];
      S_SH_RROW: a_addr = j[AW-1:0];
      S_SH_ROW: begin
        a_addr  = j[AW-1:0];
        a_we    = 1'b1;
        a_wdata = {row_new, aux_pow};
      end
      S_SH_RPOW: begin
        a_addr = AW'(i - j);
        c_addr = j[AW-1:0];
      end
      S_SH_MB: begin
        mul_a = 33'(f);
        mul_b = {1'b0, binom[31:0]};
        mul_q = 1'b0;
      end
      S_SH_MQ: begin
        mul_a = 33'(sb);
        mul_b = 33'(pw);
      end
      S_SH_ADD: begin
        add_a   = cj;
        add_b   = 33'(mul_o.val);
        c_addr  = j[AW-1:0];
        c_we    = 1'b1;
        c_wdata = add_o.val;
        mul_a   = 33'(roll);
        mul_b   = 33'(cur);
      end
      S_SH_WRI: begin
        c_addr  = i[AW-1:0];
        c_we    = 1'b1;
        c_wdata = roll;
      end
      default: begin
      end
    endcase
  end

  assign cmd_stall = (state != S_IDLE);

  // Sequencer state, working registers and the response register.
  always_ff @(posedge clk) begin
    rd_vld <= vld[c_addr];
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      vld       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (c_we) vld[c_addr] <= 1'b1;
      if (rsp_valid && !rsp_stall && state != S_DONE) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd_word.cmd;
            idx_q <= cmd_word.index;
            sub_q <= cmd_word.subtract;
            val_q <= cmd_word.value;
            res   <= '0;
            sat   <= 1'b0;
            i     <= '0;
            m     <= pce_pkg::Q_ONE;
            unique case (cmd_word.cmd)
              pce_pkg::CMD_WRITE, pce_pkg::CMD_ADDSUB: begin
                if (idx_ok) begin
                  if (5'(cmd_word.index) >= count) count <= 5'(cmd_word.index) + 5'd1;
                  state <= (cmd_word.cmd == pce_pkg::CMD_WRITE) ? S_WR : S_RMW_RD;
                end else begin
                  state <= S_DONE;
                end
              end
              pce_pkg::CMD_READ: state <= S_RD;
              pce_pkg::CMD_EVAL: begin
                i     <= cnt_w;
                state <= S_EV_CHK;
              end
              pce_pkg::CMD_ADDC: begin
                if (count == 5'd0) count <= 5'd1;
                state <= S_RMW_RD;
              end
              pce_pkg::CMD_SCALE:  state <= S_SC_RD;
              pce_pkg::CMD_SCALEX: state <= S_SX_RD;
              pce_pkg::CMD_SHIFT, pce_pkg::CMD_SHINC: begin
                state <= (cmd_word.value == 0 || count == 5'd0) ? S_DONE : S_SH_P0;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_WR: state <= S_DONE;
        S_RD: state <= S_RD_W;
        S_RD_W: begin
          if (idx_q_ok && CW'(idx_q) < cnt_w) res <= crd_m;
          state <= S_DONE;
        end
        // Horner evaluation from the top coefficient down.
        S_EV_CHK: state <= (i == '0) ? S_DONE : S_EV_ACC;
        S_EV_ACC: begin
          res   <= add_o.val;
          sat   <= sat | mul_o.sat | add_o.sat;
          i     <= i - CW'(1);
          state <= S_EV_CHK;
        end
        // Single-entry read, add and write back.
        S_RMW_RD: state <= S_RMW_WR;
        S_RMW_WR: begin
          sat   <= sat | add_o.sat;
          state <= S_DONE;
        end
        // Scale every coefficient by the same factor.
        S_SC_RD:  state <= (i == cnt_w) ? S_DONE : S_SC_MUL;
        S_SC_MUL: state <= S_SC_WR;
        S_SC_WR: begin
          sat   <= sat | mul_o.sat;
          i     <= i + CW'(1);
          state <= S_SC_RD;
        end
        // Scale x: the running power advances only when another term needs it.
        S_SX_RD:  state <= (i == cnt_w) ? S_DONE : S_SX_MUL;
        S_SX_MUL: state <= S_SX_WR;
        S_SX_WR: begin
          sat <= sat | mul_o.sat;
          if (i + CW'(1) < cnt_w) begin
            state <= S_SX_M2;
          end else begin
            i     <= i + CW'(1);
            state <= S_SX_RD;
          end
        end
        S_SX_M2: begin
          m     <= mul_o.val;
          sat   <= sat | mul_o.sat;
          i     <= i + CW'(1);
          state <= S_SX_RD;
        end
        // Power table d^0..d^(n-1), with the binomial row seeded to 1, 0, 0...
        S_SH_P0: begin
          m     <= pce_pkg::Q_ONE;
          k     <= CW'(1);
          state <= S_SH_PCHK;
        end
        S_SH_PCHK: begin
          if (k == cnt_w) begin
            i     <= CW'(1);
            state <= S_SH_ICHK;
          end else begin
            state <= S_SH_PWR;
          end
        end
        S_SH_PWR: begin
          m     <= mul_o.val;
          sat   <= sat | mul_o.sat;
          k     <= k + CW'(1);
          state <= S_SH_PCHK;
        end
        // Outer loop over powers i: fetch the coefficient being expanded.
        S_SH_ICHK: begin
          j        <= '0;
          prev_row <= '0;
          roll     <= pce_pkg::Q_ONE;
          state    <= (i == cnt_w) ? S_DONE : S_SH_CUR;
        end
        S_SH_CUR: begin
          cur   <= crd_m;
          state <= S_SH_RROW;
        end
        S_SH_RROW: state <= S_SH_ROW;
        // Advance the row entry j to C(i, j), then spread the term if needed.
        S_SH_ROW: begin
          prev_row <= aux_row;
          binom    <= row_new;
          if (j == i) begin
            if (cur != 0 && inc) begin
              state <= S_SH_WRI;
            end else begin
              i     <= i + CW'(1);
              state <= S_SH_ICHK;
            end
          end else if (cur == 0) begin
            j     <= j + CW'(1);
            state <= S_SH_RROW;
          end else begin
            state <= S_SH_RPOW;
          end
        end
        S_SH_RPOW: state <= S_SH_MB;
        S_SH_MB: begin
          pw    <= aux_pow;
          cj    <= crd_m;
          state <= S_SH_SB;
        end
        // Factor times binomial, clamped; a capped binomial saturates outright.
        S_SH_SB: begin
          if (f == 0 || binom == '0) begin
            sb <= '0;
          end else if (binom[32]) begin
            sb  <= (f < 0) ? pce_pkg::Q_MIN : pce_pkg::Q_MAX;
            sat <= 1'b1;
          end else begin
            sb  <= mul_o.val;
            sat <= sat | mul_o.sat;
          end
          state <= S_SH_MQ;
        end
        S_SH_MQ: state <= S_SH_ADD;
        S_SH_ADD: begin
          sat <= sat | mul_o.sat | add_o.sat;
          if (inc) begin
            state <= S_SH_ROLL;
          end else begin
            j     <= j + CW'(1);
            state <= S_SH_RROW;
          end
        end
        S_SH_ROLL: begin
          roll  <= mul_o.val;
          sat   <= sat | mul_o.sat;
          j     <= j + CW'(1);
          state <= S_SH_RROW;
        end
        S_SH_WRI: begin
          i     <= i + CW'(1);
          state <= S_SH_ICHK;
        end
        // Hand the response word over once the output register is free.
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid             <= 1'b1;
            rsp_word.result_value <= res;
            rsp_word.term_count   <= count;
            rsp_word.overflow     <= sat;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A taken command word blocks further words until its response is formed.
  `PCE_ASSERT_NXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall, "word not started")
  // The term count never shrinks.
  `PCE_ASSERT_NXT(a_count_mono, 1'b1, count >= $past(count), "term count decreased")
  // Finishing a command always presents a response word.
  `PCE_ASSERT_NXT(a_done_rsp, state == S_DONE && !(rsp_valid && rsp_stall), rsp_valid, "rsp lost")
  // The term count stays within the table.
  `PCE_ASSERT_IMP(a_count_max, 1'b1, CW'(count) <= CW'(MAX_TERMS), "term count beyond table")

endmodule

@@ sim/tb.sv @@
// Testbench for polynomial_coefficient_engine: directed and random command words,
// checked against an in-bench fixed-point model. Depends on pce_pkg and the RTL top.
`timescale 1ns / 100ps

module tb;

  localparam int TERMS = pce_pkg::MAX_TERMS_DEF;
  localparam int RANDOM_WORDS = 400;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  pce_pkg::cmd_word_t cmd_word;
  logic rsp_valid;
  logic rsp_stall;
  pce_pkg::rsp_word_t rsp_word;

  polynomial_coefficient_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

  // Shadow copy of the coefficient table and its term count.
  logic signed [31:0] shadow_coef [TERMS];
  logic [4:0] shadow_terms;
  logic signed [31:0] shadow_power [TERMS];
  logic saturated;

  pce_pkg::cmd_word_t pending_words[$];
  pce_pkg::rsp_word_t expected_rsp[$];
  int total_words;
  int accepted_words;
  int checked_words;
  int error_count;
  int overflow_seen;
  int cmd_seen [16];

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      saturated = 1'b1;
      return pce_pkg::Q_MAX;
    end
    if (v < -64'sd2147483648) begin
      saturated = 1'b1;
      return pce_pkg::Q_MIN;
    end
    return v[31:0];
  endfunction

  // Q16.16 product, rounded half up, then clamped.
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    longint t;
    t = longint'(a) * longint'(b) + 64'sd32768;
    return clamp32(t >>> 16);
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [31:0] a, input longint b);
    return clamp32(longint'(a) + b);
  endfunction

  function automatic logic signed [31:0] times_binom(input logic signed [31:0] f,
                                                     input longint unsigned b);
    if (f == 0 || b == 0) return '0;
    if (b >= 64'h1_0000_0000) begin
      saturated = 1'b1;
      return (f > 0) ? pce_pkg::Q_MAX : pce_pkg::Q_MIN;
    end
    return clamp32(longint'(f) * longint'(b));
  endfunction

  // Rewrites the table for p(x+d), or for the incremental variant.
  function automatic void taylor_shift(input logic signed [31:0] d, input logic inc);
    longint unsigned row [TERMS];
    int n;
    logic signed [31:0] cur;
    logic signed [31:0] roll;
    logic signed [31:0] f;
    logic signed [31:0] term;
    n = shadow_terms;
    if (d == 0 || n == 0) return;
    shadow_power[0] = pce_pkg::Q_ONE;
    for (int k = 1; k < n; k++) shadow_power[k] = fx_mul(shadow_power[k-1], d);
    for (int k = 0; k < TERMS; k++) row[k] = 0;
    row[0] = 1;
    for (int i = 1; i < n; i++) begin
      cur = shadow_coef[i];
      roll = pce_pkg::Q_ONE;
      for (int k = i; k >= 1; k--) row[k] = row[k] + row[k-1];
      if (cur == 0) continue;
      for (int j = 0; j < i; j++) begin
        f = inc ? roll : cur;
        term = fx_mul(times_binom(f, row[j]), shadow_power[i-j]);
        shadow_coef[j] = fx_add(shadow_coef[j], longint'(term));
        if (inc) roll = fx_mul(roll, cur);
      end
      if (inc) shadow_coef[i] = roll;
    end
  endfunction

  // Applies one command word to the shadow state and returns the response word.
  function automatic pce_pkg::rsp_word_t run_command(input pce_pkg::cmd_word_t w);
    pce_pkg::rsp_word_t r;
    logic signed [31:0] acc;
    logic signed [31:0] m;
    acc = '0;
    saturated = 1'b0;
    case (w.cmd)
      pce_pkg::CMD_WRITE: begin
        shadow_coef[w.index] = w.value;
        if (w.index >= shadow_terms) shadow_terms = 5'(w.index) + 5'd1;
      end
      pce_pkg::CMD_READ: begin
        if (w.index < shadow_terms) acc = shadow_coef[w.index];
      end
      pce_pkg::CMD_EVAL: begin
        for (int i = shadow_terms; i > 0; i--)
          acc = fx_add(fx_mul(acc, w.value), longint'(shadow_coef[i-1]));
      end
      pce_pkg::CMD_ADDC: begin
        if (shadow_terms < 1) shadow_terms = 5'd1;
        shadow_coef[0] = fx_add(shadow_coef[0], longint'(w.value));
      end
      pce_pkg::CMD_SCALE: begin
        for (int i = 0; i < shadow_terms; i++) shadow_coef[i] = fx_mul(shadow_coef[i], w.value);
      end
      pce_pkg::CMD_SCALEX: begin
        m = pce_pkg::Q_ONE;
        for (int i = 0; i < shadow_terms; i++) begin
          shadow_coef[i] = fx_mul(shadow_coef[i], m);
          if (i + 1 < shadow_terms) m = fx_mul(m, w.value);
        end
      end
      pce_pkg::CMD_SHIFT: taylor_shift(w.value, 1'b0);
      pce_pkg::CMD_SHINC: taylor_shift(w.value, 1'b1);
      pce_pkg::CMD_ADDSUB: begin
        if (w.index >= shadow_terms) shadow_terms = 5'(w.index) + 5'd1;
        shadow_coef[w.index] = fx_add(shadow_coef[w.index],
                                      w.subtract ? -longint'(w.value) : longint'(w.value));
      end
      default: ;
    endcase
    r.result_value = acc;
    r.term_count = shadow_terms;
    r.overflow = saturated;
    return r;
  endfunction

  function automatic pce_pkg::cmd_word_t make_word(input logic [3:0] c,
                                                   input logic [3:0] idx,
                                                   input logic sub,
                                                   input logic signed [31:0] v);
    pce_pkg::cmd_word_t w;
    w.cmd = c;
    w.index = idx;
    w.subtract = sub;
    w.value = v;
    return w;
  endfunction

  // Mostly modest Q16.16 values, with full-range and extreme values mixed in.
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 11) return $signed($urandom_range(0, 32'h0005_FFFF)) - 32'sh0003_0000;
    if (sel < 13) return '0;
    if (sel < 15) return $urandom();
    if (sel == 15) return pce_pkg::Q_MAX;
    if (sel == 16) return pce_pkg::Q_MIN;
    if (sel == 17) return pce_pkg::Q_ONE;
    return -pce_pkg::Q_ONE;
  endfunction

  // Clock and the single reset.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: sends queued words in bursts and predicts each accepted word.
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd_word <= '0;
      burst_left <= 4;
      gap_left <= 0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        expected_rsp.push_back(run_command(cmd_word));
        cmd_seen[cmd_word.cmd]++;
        accepted_words++;
      end
      if (!cmd_valid || !cmd_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          cmd_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cmd_valid <= 1'b1;
          cmd_word <= pending_words.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls in runs of random length and level.
  int stall_run;

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      rsp_stall <= ($urandom_range(0, 2) == 0);
      stall_run <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 6);
    end
  end

  // Monitor: compares each taken response word with the oldest prediction.
  pce_pkg::rsp_word_t want;

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected response word %h", rsp_word);
        error_count++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_word.result_value !== want.result_value) begin
          $error("result_value expected %h got %h", want.result_value, rsp_word.result_value);
          error_count++;
        end
        if (rsp_word.term_count !== want.term_count) begin
          $error("term_count expected %0d got %0d", want.term_count, rsp_word.term_count);
          error_count++;
        end
        if (rsp_word.overflow !== want.overflow) begin
          $error("overflow expected %b got %b", want.overflow, rsp_word.overflow);
          error_count++;
        end
        if (want.overflow) overflow_seen++;
      end
      checked_words++;
    end
  end

  // Stimulus: directed corner cases, then growing random polynomials.
  initial begin
    int idx_cap;
    int sel;
    logic [3:0] c;
    for (int i = 0; i < TERMS; i++) begin
      shadow_coef[i] = '0;
      shadow_power[i] = '0;
    end
    shadow_terms = '0;
    saturated = 1'b0;
    accepted_words = 0;
    checked_words = 0;
    error_count = 0;
    overflow_seen = 0;
    for (int i = 0; i < 16; i++) cmd_seen[i] = 0;

    // Empty table cases, first additions and writes, and shifts by zero.
    pending_words.push_back(make_word(pce_pkg::CMD_EVAL, 4'd0, 1'b0, pce_pkg::Q_ONE));
    pending_words.push_back(make_word(pce_pkg::CMD_READ, 4'd3, 1'b0, '0));
    pending_words.push_back(make_word(pce_pkg::CMD_SHIFT, 4'd0, 1'b0, pce_pkg::Q_ONE));
    pending_words.push_back(make_word(pce_pkg::CMD_ADDC, 4'd0, 1'b0, 32'sh0002_8000));
    pending_words.push_back(make_word(pce_pkg::CMD_ADDC, 4'd0, 1'b0, pce_pkg::Q_MAX));
    pending_words.push_back(make_word(pce_pkg::CMD_WRITE, 4'd2, 1'b0, 32'sh0001_8000));
    pending_words.push_back(make_word(pce_pkg::CMD_READ, 4'd1, 1'b0, '0));
    pending_words.push_back(make_word(pce_pkg::CMD_SHIFT, 4'd0, 1'b0, '0));
    pending_words.push_back(make_word(pce_pkg::CMD_SHINC, 4'd0, 1'b0, '0));
    // A small polynomial through shifts, evaluation, scaling and add/subtract, then invalid codes.
    pending_words.push_back(make_word(pce_pkg::CMD_WRITE, 4'd0, 1'b0, -pce_pkg::Q_ONE));
    pending_words.push_back(make_word(pce_pkg::CMD_SHIFT, 4'd0, 1'b0, 32'sh0002_0000));
    pending_words.push_back(make_word(pce_pkg::CMD_SHINC, 4'd0, 1'b0, -32'sh0000_8000));
    pending_words.push_back(make_word(pce_pkg::CMD_EVAL, 4'd0, 1'b0, 32'sh0003_4000));
    pending_words.push_back(make_word(pce_pkg::CMD_SCALE, 4'd0, 1'b0, -32'sh0001_8000));
    pending_words.push_back(make_word(pce_pkg::CMD_SCALEX, 4'd0, 1'b0, 32'sh0000_C000));
    pending_words.push_back(make_word(pce_pkg::CMD_ADDSUB, 4'd1, 1'b1, pce_pkg::Q_MIN));
    pending_words.push_back(make_word(pce_pkg::CMD_ADDSUB, 4'd4, 1'b0, pce_pkg::Q_MIN));
    pending_words.push_back(make_word(pce_pkg::CMD_SCALE, 4'd0, 1'b0, pce_pkg::Q_MAX));
    pending_words.push_back(make_word(pce_pkg::CMD_EVAL, 4'd0, 1'b0, pce_pkg::Q_MIN));
    pending_words.push_back(make_word(4'd9, 4'd5, 1'b1, 32'sh1234_5678));
    pending_words.push_back(make_word(4'd15, 4'd10, 1'b0, pce_pkg::Q_MIN));
    pending_words.push_back(make_word(pce_pkg::CMD_READ, 4'd4, 1'b0, '0));

    // Random part: the highest index grows slowly so most shifts stay short.
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      idx_cap = (k / 28 < 15) ? k / 28 + 1 : 15;
      if (k == RANDOM_WORDS - 40) idx_cap = 15;
      sel = $urandom_range(0, 99);
      if (sel < 30) c = pce_pkg::CMD_WRITE;
      else if (sel < 42) c = pce_pkg::CMD_READ;
      else if (sel < 52) c = pce_pkg::CMD_EVAL;
      else if (sel < 58) c = pce_pkg::CMD_ADDC;
      else if (sel < 64) c = pce_pkg::CMD_SCALE;
      else if (sel < 70) c = pce_pkg::CMD_SCALEX;
      else if (sel < 78) c = pce_pkg::CMD_SHIFT;
      else if (sel < 86) c = pce_pkg::CMD_SHINC;
      else if (sel < 96) c = pce_pkg::CMD_ADDSUB;
      else c = 4'($urandom_range(9, 15));
      pending_words.push_back(make_word(c,
          4'($urandom_range(0, (k == RANDOM_WORDS - 40) ? 15 : idx_cap)),
          1'($urandom_range(0, 1)), pick_value()));
    end
    pending_words.push_back(make_word(pce_pkg::CMD_WRITE, 4'd15, 1'b0, 32'sh0000_4000));
    pending_words.push_back(make_word(pce_pkg::CMD_SHINC, 4'd0, 1'b1, 32'sh0000_8000));
    pending_words.push_back(make_word(pce_pkg::CMD_READ, 4'd15, 1'b1, '0));
    total_words = pending_words.size();

    @(negedge rst);
    wait (accepted_words == total_words && checked_words == accepted_words);
    repeat (100) @(posedge clk);
    $display("Sent %0d command words: %0d writes, %0d reads, %0d evaluations, %0d shifts.",
             total_words, cmd_seen[pce_pkg::CMD_WRITE], cmd_seen[pce_pkg::CMD_READ],
             cmd_seen[pce_pkg::CMD_EVAL],
             cmd_seen[pce_pkg::CMD_SHIFT] + cmd_seen[pce_pkg::CMD_SHINC]);
    $display("Checked %0d response words, %0d of them with saturation.",
             checked_words, overflow_seen);
    if (error_count == 0 && expected_rsp.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Run limit, well past the slowest legal run.
  initial begin
    #60_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pce_pkg.sv
rtl/pce_ram.sv
rtl/pce_mul.sv
rtl/polynomial_coefficient_engine.sv
sim/tb.sv
